/* src/htw_pkg.sv */
package htw_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int LOW_BITS_DEF  = 8;
    localparam int HIGH_BITS_DEF = 6;
    localparam int NLEVELS       = 4;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_STOP  = 2'd1,
        MODE_ADV   = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STS_STARTED   = 3'd0,
        STS_RUNNING   = 3'd1,
        STS_TOO_FAR   = 3'd2,
        STS_STOPPED   = 3'd3,
        STS_NOT_RUN   = 3'd4,
        STS_EXPIRED   = 3'd5,
        STS_TICK_NONE = 3'd6,
        STS_CAUGHT_UP = 3'd7
    } t_status;

endpackage

/* src/htw_if.sv */
interface htw_req_if;
    logic                        valid;
    logic                        ready;
    logic [htw_pkg::MODE_W-1:0]  mode;
    logic [htw_pkg::SLOT_W-1:0]  slot_id;
    logic [htw_pkg::TIME_W-1:0]  time_value;

    modport source (output valid, mode, slot_id, time_value, input ready);
    modport sink   (input valid, mode, slot_id, time_value, output ready);
endinterface

interface htw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [htw_pkg::SLOT_W-1:0]    slot_out;
    logic [htw_pkg::STATUS_W-1:0]  status;
    logic                          last;
    logic                          still_behind;
    logic [htw_pkg::COUNT_W-1:0]   active_count;

    modport source (output valid, slot_out, status, last, still_behind, active_count,
                    input ready);
    modport sink   (input valid, slot_out, status, last, still_behind, active_count,
                    output ready);
endinterface

/* src/htw_ram.sv */
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/hierarchical_timer_wheel_core.sv */
// Timer wheel core: one request at a time, state held in synchronous RAMs.
// Start files the timer in a bucket, else reports it as already running or too far;
// stop unlinks a running timer, else reports it as not running; advance cascades the
// visited upper buckets unless caught up, then a tick emits expired slots one at a time.
// Reset (synchronous, active low) runs a clearing pass over all 2^LOW_BITS + 4*2^HIGH_BITS
// entries of the bucket-head RAM (512 by default), one entry a cycle.
module hierarchical_timer_wheel_core #(
    parameter int SLOTS     = htw_pkg::SLOTS_DEF,
    parameter int LOW_BITS  = htw_pkg::LOW_BITS_DEF,
    parameter int HIGH_BITS = htw_pkg::HIGH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [htw_pkg::TIME_W-1:0]  i_cfg_data,
    htw_req_if.sink                     i_req,
    htw_rsp_if.source                   o_rsp
);

    localparam int SIW       = $clog2(SLOTS);
    localparam int LOW_SIZE  = 1 << LOW_BITS;
    localparam int HIGH_SIZE = 1 << HIGH_BITS;
    localparam int NB        = LOW_SIZE + htw_pkg::NLEVELS * HIGH_SIZE;
    localparam int BW        = $clog2(NB);
    localparam int TW        = htw_pkg::TIME_W;
    localparam int CW        = htw_pkg::COUNT_W;

    typedef struct packed {
        logic           ok;
        logic [SIW-1:0] idx;
    } t_link;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_F0, ST_F1, ST_F2, ST_U0, ST_U1, ST_A0, ST_C1, ST_C2,
        ST_C3, ST_CN, ST_T0, ST_T1, ST_E0, ST_E1, ST_EMIT
    } t_state;

    t_state                    r_state;
    logic [BW-1:0]             r_clr;
    logic [TW-1:0]             r_wt;
    logic [TW-1:0]             r_tv;
    logic [TW-1:0]             r_e;
    logic [CW-1:0]             r_active;
    logic [SLOTS-1:0]          r_filed;
    logic [SIW-1:0]            r_s;
    logic [SIW-1:0]            r_cur;
    logic                      r_ok;
    t_link                     r_hd;
    t_link                     r_n;
    logic [BW-1:0]             r_b;
    logic [1:0]                r_lvl;
    logic                      r_casc;
    logic                      r_more;
    logic                      r_behind;
    logic [htw_pkg::SLOT_W-1:0] r_pslot;
    htw_pkg::t_status          r_pst;
    logic                      r_plast;

    logic                      r_ov;
    logic [htw_pkg::SLOT_W-1:0] r_oslot;
    htw_pkg::t_status          r_ost;
    logic                      r_olast;
    logic                      r_obehind;
    logic [CW-1:0]             r_ocount;

    // RAM ports
    logic          hd_we;
    logic [BW-1:0] hd_waddr, hd_raddr;
    t_link         hd_wdata, hd_rdata;
    logic           nx_we, pv_we, bk_we, ex_we;
    logic [SIW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
    logic [SIW-1:0] bk_waddr, bk_raddr, ex_waddr, ex_raddr;
    t_link          nx_wdata, nx_rdata, pv_wdata, pv_rdata;
    logic [BW-1:0]  bk_wdata, bk_rdata;
    logic [TW-1:0]  ex_wdata, ex_rdata;

    logic           w_acc;
    logic           w_in_range;
    logic           w_out_free;
    logic [TW-1:0]  w_diff;
    logic           w_found;
    logic [BW-1:0]  w_bkt;
    logic [HIGH_BITS-1:0] w_hi;
    logic [BW-1:0]  w_cbkt;
    logic [BW-1:0]  w_low;

    function automatic logic [HIGH_BITS-1:0] f_hi(input logic [TW-1:0] t, input logic [1:0] n);
        logic [TW-1:0] v;
        case (n)
            2'd0:    v = t >> LOW_BITS;
            2'd1:    v = t >> (LOW_BITS + HIGH_BITS);
            2'd2:    v = t >> (LOW_BITS + 2 * HIGH_BITS);
            2'd3:    v = t >> (LOW_BITS + 3 * HIGH_BITS);
            default: v = '0;
        endcase
        return v[HIGH_BITS-1:0];
    endfunction

    assign w_acc      = i_req.valid && (r_state == ST_IDLE);
    assign w_in_range = (32'(i_req.slot_id) < SLOTS);
    assign w_out_free = !r_ov || o_rsp.ready;
    assign w_low      = BW'(r_wt[LOW_BITS-1:0]);
    assign w_hi       = f_hi(r_wt, r_lvl);
    assign w_cbkt     = BW'(LOW_SIZE) + (BW'(r_lvl) << HIGH_BITS) + BW'(w_hi);

    // Pick the bucket for a timer from its distance to the wheel time
    always_comb begin
        w_diff  = r_e - r_wt;
        w_found = 1'b0;
        w_bkt   = '0;
        if (r_e < r_wt) begin
            w_found = 1'b1;
            w_bkt   = w_low;
        end else if ((w_diff >> LOW_BITS) == '0) begin
            w_found = 1'b1;
            w_bkt   = BW'(r_e[LOW_BITS-1:0]);
        end else begin
            for (int n = 0; n < htw_pkg::NLEVELS; n++) begin
                if (!w_found && ((w_diff >> (LOW_BITS + (n + 1) * HIGH_BITS)) == '0)) begin
                    w_found = 1'b1;
                    w_bkt   = BW'(LOW_SIZE + n * HIGH_SIZE) + BW'(f_hi(r_e, 2'(n)));
                end
            end
        end
    end

    always_comb begin
        hd_we = 1'b0; hd_waddr = r_b; hd_wdata = '0; hd_raddr = r_b;
        nx_we = 1'b0; nx_waddr = r_s; nx_wdata = '0; nx_raddr = r_cur;
        pv_we = 1'b0; pv_waddr = r_s; pv_wdata = '0; pv_raddr = r_s;
        bk_we = 1'b0; bk_waddr = r_s; bk_wdata = r_b; bk_raddr = r_s;
        ex_we = 1'b0; ex_waddr = SIW'(i_req.slot_id); ex_wdata = i_req.time_value;
        ex_raddr = r_cur;
        case (r_state)
            ST_CLR: begin
                hd_we    = 1'b1;
                hd_waddr = r_clr;
            end
            ST_IDLE: begin
                // keep the expiry of a running timer
                ex_we = w_acc && (htw_pkg::t_mode'(i_req.mode) == htw_pkg::MODE_START) &&
                        w_in_range && !r_filed[SIW'(i_req.slot_id)];
            end
            ST_F0: begin
                hd_raddr = w_bkt;
            end
            ST_F1: begin
                hd_we    = 1'b1;
                hd_wdata = '{ok: 1'b1, idx: r_s};
                nx_we    = 1'b1;
                nx_wdata = hd_rdata;
                pv_we    = 1'b1;
                bk_we    = 1'b1;
            end
            ST_F2: begin
                pv_we    = r_hd.ok;
                pv_waddr = r_hd.idx;
                pv_wdata = '{ok: 1'b1, idx: r_s};
            end
            ST_U0: begin
                nx_raddr = r_s;
            end
            ST_U1: begin
                if (pv_rdata.ok) begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata.idx;
                    nx_wdata = nx_rdata;
                end else begin
                    hd_we    = 1'b1;
                    hd_waddr = bk_rdata;
                    hd_wdata = nx_rdata;
                end
                pv_we    = nx_rdata.ok;
                pv_waddr = nx_rdata.idx;
                pv_wdata = pv_rdata;
            end
            ST_A0: begin
                hd_raddr = w_cbkt;
            end
            ST_C1: begin
                hd_we = 1'b1;
            end
            ST_T0: begin
                hd_raddr = w_low;
            end
            ST_T1: begin
                hd_we    = 1'b1;
                hd_waddr = w_low;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_wt     <= '0;
            r_active <= '0;
            r_filed  <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && o_rsp.ready && (r_state != ST_EMIT)) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                r_wt <= i_cfg_data;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BW'(NB - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        r_tv     <= i_req.time_value;
                        r_e      <= i_req.time_value;
                        r_pslot  <= (htw_pkg::t_mode'(i_req.mode) == htw_pkg::MODE_ADV) ?
                                    '0 : i_req.slot_id;
                        r_s      <= SIW'(i_req.slot_id);
                        r_casc   <= 1'b0;
                        r_more   <= 1'b0;
                        r_behind <= 1'b0;
                        r_plast  <= 1'b1;
                        case (htw_pkg::t_mode'(i_req.mode))
                            htw_pkg::MODE_START: begin
                                if (!w_in_range) begin
                                    r_pst   <= htw_pkg::STS_TOO_FAR;
                                    r_state <= ST_EMIT;
                                end else if (r_filed[SIW'(i_req.slot_id)]) begin
                                    r_pst   <= htw_pkg::STS_RUNNING;
                                    r_state <= ST_EMIT;
                                end else begin
                                    r_state <= ST_F0;
                                end
                            end
                            htw_pkg::MODE_STOP: begin
                                if (w_in_range && r_filed[SIW'(i_req.slot_id)]) begin
                                    r_state <= ST_U0;
                                end else begin
                                    r_pst   <= htw_pkg::STS_NOT_RUN;
                                    r_state <= ST_EMIT;
                                end
                            end
                            htw_pkg::MODE_ADV: begin
                                if (!(r_wt < i_req.time_value)) begin
                                    r_pst   <= htw_pkg::STS_CAUGHT_UP;
                                    r_state <= ST_EMIT;
                                end else if (r_wt[LOW_BITS-1:0] == '0) begin
                                    r_lvl   <= '0;
                                    r_state <= ST_A0;
                                end else begin
                                    r_state <= ST_T0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_F0: begin
                    r_b <= w_bkt;
                    if (w_found) begin
                        r_state <= ST_F1;
                    end else if (r_casc) begin
                        r_state <= ST_CN;
                    end else begin
                        r_pst   <= htw_pkg::STS_TOO_FAR;
                        r_state <= ST_EMIT;
                    end
                end
                ST_F1: begin
                    r_hd          <= hd_rdata;
                    r_filed[r_s]  <= 1'b1;
                    r_active      <= r_active + 1'b1;
                    r_state       <= ST_F2;
                end
                ST_F2: begin
                    if (r_casc) begin
                        r_state <= ST_CN;
                    end else begin
                        r_pst   <= htw_pkg::STS_STARTED;
                        r_state <= ST_EMIT;
                    end
                end
                ST_U0: begin
                    r_state <= ST_U1;
                end
                ST_U1: begin
                    r_filed[r_s] <= 1'b0;
                    r_active     <= r_active - 1'b1;
                    r_pst        <= htw_pkg::STS_STOPPED;
                    r_state      <= ST_EMIT;
                end
                ST_A0: begin
                    r_b     <= w_cbkt;
                    r_state <= ST_C1;
                end
                ST_C1: begin
                    r_ok    <= hd_rdata.ok;
                    r_cur   <= hd_rdata.idx;
                    r_state <= ST_C2;
                end
                ST_C2: begin
                    if (r_ok) begin
                        r_s     <= r_cur;
                        r_state <= ST_C3;
                    end else if ((w_hi != '0) || (r_lvl == 2'(htw_pkg::NLEVELS - 1))) begin
                        r_state <= ST_T0;
                    end else begin
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= ST_A0;
                    end
                end
                ST_C3: begin
                    r_n          <= nx_rdata;
                    r_e          <= ex_rdata;
                    r_filed[r_s] <= 1'b0;
                    r_active     <= r_active - 1'b1;
                    r_casc       <= 1'b1;
                    r_state      <= ST_F0;
                end
                ST_CN: begin
                    r_ok    <= r_n.ok;
                    r_cur   <= r_n.idx;
                    r_state <= ST_C2;
                end
                ST_T0: begin
                    r_state <= ST_T1;
                end
                ST_T1: begin
                    r_wt     <= r_wt + 1'b1;
                    r_behind <= ((r_wt + 1'b1) != r_tv);
                    r_cur    <= hd_rdata.idx;
                    if (hd_rdata.ok) begin
                        r_state <= ST_E0;
                    end else begin
                        r_pslot <= '0;
                        r_pst   <= htw_pkg::STS_TICK_NONE;
                        r_plast <= 1'b1;
                        r_more  <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_E0: begin
                    r_state <= ST_E1;
                end
                ST_E1: begin
                    r_filed[r_cur] <= 1'b0;
                    r_active       <= r_active - 1'b1;
                    r_pslot        <= htw_pkg::SLOT_W'(r_cur);
                    r_pst          <= htw_pkg::STS_EXPIRED;
                    r_plast        <= !nx_rdata.ok;
                    r_more         <= nx_rdata.ok;
                    r_cur          <= nx_rdata.idx;
                    r_state        <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_ov      <= 1'b1;
                        r_oslot   <= r_pslot;
                        r_ost     <= r_pst;
                        r_olast   <= r_plast;
                        r_obehind <= r_behind;
                        r_ocount  <= r_active;
                        r_state   <= r_more ? ST_E0 : ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_ov;
    assign o_rsp.slot_out      = r_oslot;
    assign o_rsp.status        = r_ost;
    assign o_rsp.last          = r_olast;
    assign o_rsp.still_behind  = r_obehind;
    assign o_rsp.active_count  = r_ocount;

    htw_ram #(.WIDTH(SIW + 1), .DEPTH(NB)) u_head_ram (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_rdata)
    );

    htw_ram #(.WIDTH(SIW + 1), .DEPTH(SLOTS)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_rdata)
    );

    htw_ram #(.WIDTH(SIW + 1), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(pv_raddr), .o_rdata(pv_rdata)
    );

    htw_ram #(.WIDTH(BW), .DEPTH(SLOTS)) u_bucket_ram (
        .i_clk(i_clk), .i_we(bk_we), .i_waddr(bk_waddr), .i_wdata(bk_wdata),
        .i_raddr(bk_raddr), .o_rdata(bk_rdata)
    );

    htw_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_expiry_ram (
        .i_clk(i_clk), .i_we(ex_we), .i_waddr(ex_waddr), .i_wdata(ex_wdata),
        .i_raddr(ex_raddr), .o_rdata(ex_rdata)
    );

endmodule
